[src/b2nv12_pkg.sv]
`default_nettype none

package b2nv12_pkg;

  // default frame limits
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // field and counter widths
  localparam int CNT_W     = 13;        // size registers, column and row counters
  localparam int DIM_W     = CNT_W + 1; // kept sizes and incremented counters
  localparam int LADDR_W   = 24;
  localparam int CADDR_W   = 23;
  localparam int CHAN_W    = 8;
  localparam int SUM_W     = 9;         // sum of two channel values
  localparam int PAIR_W    = 3 * SUM_W;
  localparam int PIXEL_W   = 32;
  localparam int CFG_W     = 32;
  localparam int PADDR_W   = 3;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // register reset values
  localparam logic [CNT_W-1:0] WIDTH_RESET  = 13'd1920;
  localparam logic [CNT_W-1:0] HEIGHT_RESET = 13'd1080;

  // register indexes (paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // what the back does with a beat
  typedef enum logic [1:0] {
    OP_LUMA,   // luma only, left pixel of a pair
    OP_STORE,  // luma, pair sum goes to the line store
    OP_BLOCK   // luma, pair sum plus stored sum completes a 2x2 block
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [CNT_W-2:0]   col_half;    // column / 2, line store index
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [PAIR_W-1:0]  pair;        // {red, green, blue} pair sums
    logic [LADDR_W-1:0] luma_addr;
    logic [CADDR_W-1:0] chroma_addr;
    logic               frame_end;
  } beat_t;

endpackage

`default_nettype wire

[src/b2nv12_front.sv]
`default_nettype none

module b2nv12_front #(
  parameter int MAX_WIDTH  = b2nv12_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = b2nv12_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [b2nv12_pkg::CNT_W-1:0]  source_width,
  input  wire logic [b2nv12_pkg::CNT_W-1:0]  source_height,
  input  wire logic                          pixel_valid,
  output logic                               pixel_stall,
  input  wire logic [b2nv12_pkg::PIXEL_W-1:0] pixel,
  input  wire logic                          queue_full,
  output logic                               push,
  output b2nv12_pkg::beat_t                  push_beat
);
  import b2nv12_pkg::*;

  logic [CNT_W-1:0]   col;
  logic [CNT_W-1:0]   row;
  logic [LADDR_W-1:0] luma_offset;
  logic [CADDR_W-1:0] chroma_offset;
  logic [3*CHAN_W-1:0] held;

  logic [DIM_W-1:0] sw_ext, sh_ext, lim_w, lim_h, min_w, min_h, kw, kh;
  logic [DIM_W-1:0] col_ext, row_ext, col_inc, row_inc;
  logic             accept, kept;
  logic [CHAN_W-1:0] cur_b, cur_g, cur_r;
  logic [SUM_W-1:0]  pair_b, pair_g, pair_r;
  op_t               op;

  // kept area: source size limited and cropped to even
  always_comb begin
    sw_ext  = {1'b0, source_width};
    sh_ext  = {1'b0, source_height};
    lim_w   = DIM_W'(MAX_WIDTH);
    lim_h   = DIM_W'(MAX_HEIGHT);
    min_w   = (sw_ext < lim_w) ? sw_ext : lim_w;
    min_h   = (sh_ext < lim_h) ? sh_ext : lim_h;
    kw      = {min_w[DIM_W-1:1], 1'b0};
    kh      = {min_h[DIM_W-1:1], 1'b0};
    col_ext = {1'b0, col};
    row_ext = {1'b0, row};
    col_inc = col_ext + DIM_W'(1);
    row_inc = row_ext + DIM_W'(1);
    kept    = (col_ext < kw) && (row_ext < kh);
  end

  assign pixel_stall = queue_full;
  assign accept      = pixel_valid && !queue_full;
  assign push        = accept && kept;

  // classify and form horizontal pair sums
  always_comb begin
    cur_b  = pixel[7:0];
    cur_g  = pixel[15:8];
    cur_r  = pixel[23:16];
    pair_b = {1'b0, held[7:0]}   + {1'b0, cur_b};
    pair_g = {1'b0, held[15:8]}  + {1'b0, cur_g};
    pair_r = {1'b0, held[23:16]} + {1'b0, cur_r};
    if (!col[0]) begin
      op = OP_LUMA;
    end else if (row[0]) begin
      op = OP_BLOCK;
    end else begin
      op = OP_STORE;
    end
    push_beat.op          = op;
    push_beat.col_half    = col[CNT_W-1:1];
    push_beat.red         = cur_r;
    push_beat.green       = cur_g;
    push_beat.blue        = cur_b;
    push_beat.pair        = {pair_r, pair_g, pair_b};
    push_beat.luma_addr   = luma_offset;
    push_beat.chroma_addr = chroma_offset;
    push_beat.frame_end   = (row_inc == kh) && (col_inc == kw);
  end

  // raster counters and plane offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      col           <= '0;
      row           <= '0;
      luma_offset   <= '0;
      chroma_offset <= '0;
      held          <= '0;
    end else if (accept) begin
      if (kept) begin
        luma_offset <= luma_offset + LADDR_W'(1);
        if (!col[0]) begin
          held <= pixel[23:0];
        end
        if (op == OP_BLOCK) begin
          chroma_offset <= chroma_offset + CADDR_W'(2);
        end
      end
      if (col_inc >= sw_ext) begin
        col <= '0;
        if (row_inc >= sh_ext) begin
          row           <= '0;
          luma_offset   <= '0;
          chroma_offset <= '0;
        end else begin
          row <= row_inc[CNT_W-1:0];
        end
      end else begin
        col <= col_inc[CNT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

[src/b2nv12_queue.sv]
`default_nettype none

module b2nv12_queue #(
  parameter int DEPTH = b2nv12_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire b2nv12_pkg::beat_t push_beat,
  output logic                   full,
  input  wire logic              pop,
  output b2nv12_pkg::beat_t      pop_beat,
  output logic                   not_empty
);
  import b2nv12_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  beat_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_QW-1:0] count;
  logic              do_push, do_pop;

  assign full      = (count == CNT_QW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_beat  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_beat;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_QW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[src/b2nv12_back.sv]
`default_nettype none

module b2nv12_back #(
  parameter int MAX_WIDTH = b2nv12_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            not_empty,
  input  wire b2nv12_pkg::beat_t               pop_beat,
  output logic                                 pop,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output logic [b2nv12_pkg::CHAN_W-1:0]        luma,
  output logic [b2nv12_pkg::LADDR_W-1:0]       luma_addr,
  output logic                                 chroma_valid,
  output logic [b2nv12_pkg::CHAN_W-1:0]        chroma_u,
  output logic [b2nv12_pkg::CHAN_W-1:0]        chroma_v,
  output logic [b2nv12_pkg::CADDR_W-1:0]       chroma_addr,
  output logic                                 frame_end
);
  import b2nv12_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  // floor(x / 256) + 128, clamped to a byte
  function automatic logic [CHAN_W-1:0] clamp_chroma(input logic signed [17:0] x);
    logic signed [9:0] q;
    q = $signed(x[17:8]) + 10'sd128;
    if (q < 10'sd0) begin
      return '0;
    end else if (q > 10'sd255) begin
      return 8'hFF;
    end else begin
      return q[7:0];
    end
  endfunction

  logic [PAIR_W-1:0]  line_mem [LINE_DEPTH];
  logic [PAIR_W-1:0]  line_rd;
  logic [LINE_AW-1:0] line_addr;
  logic               adv;

  // stage 1: popped beat, line read data alongside
  logic  s1_valid;
  beat_t s1;

  // stage 2: luma and block averages
  logic               s2_valid, s2_block, s2_fend;
  logic [CHAN_W-1:0]  s2_y, s2_ab, s2_ag, s2_ar;
  logic [LADDR_W-1:0] s2_laddr;
  logic [CADDR_W-1:0] s2_caddr;

  logic [15:0]        luma_sum;
  logic [SUM_W:0]     blk_b, blk_g, blk_r;
  logic signed [17:0] sb, sg, sr, u_sum, v_sum;

  // whole pipe moves together when the output register is free
  assign adv       = !result_valid || !result_stall;
  assign pop       = adv && not_empty;
  assign line_addr = pop_beat.col_half[LINE_AW-1:0];

  // line store: even rows write pair sums, odd rows read them back
  always_ff @(posedge clk) begin
    if (pop && (pop_beat.op == OP_STORE)) begin
      line_mem[line_addr] <= pop_beat.pair;
    end
    if (pop && (pop_beat.op == OP_BLOCK)) begin
      line_rd <= line_mem[line_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= pop_beat;
    end
  end

  // luma and four-pixel averages
  always_comb begin
    luma_sum = 16'd77 * {8'b0, s1.red} + 16'd150 * {8'b0, s1.green}
             + 16'd29 * {8'b0, s1.blue};
    blk_b = {1'b0, line_rd[8:0]}   + {1'b0, s1.pair[8:0]};
    blk_g = {1'b0, line_rd[17:9]}  + {1'b0, s1.pair[17:9]};
    blk_r = {1'b0, line_rd[26:18]} + {1'b0, s1.pair[26:18]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_y     <= luma_sum[15:8];
      s2_ab    <= blk_b[SUM_W:2];
      s2_ag    <= blk_g[SUM_W:2];
      s2_ar    <= blk_r[SUM_W:2];
      s2_block <= (s1.op == OP_BLOCK);
      s2_laddr <= s1.luma_addr;
      s2_caddr <= s1.chroma_addr;
      s2_fend  <= s1.frame_end;
    end
  end

  // chroma weighted sums
  always_comb begin
    sb    = $signed({10'b0, s2_ab});
    sg    = $signed({10'b0, s2_ag});
    sr    = $signed({10'b0, s2_ar});
    u_sum = (sb <<< 7) - 18'sd43 * sr - 18'sd85 * sg;
    v_sum = (sr <<< 7) - 18'sd107 * sg - 18'sd21 * sb;
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      luma         <= s2_y;
      luma_addr    <= s2_laddr;
      chroma_valid <= s2_block;
      chroma_u     <= s2_block ? clamp_chroma(u_sum) : '0;
      chroma_v     <= s2_block ? clamp_chroma(v_sum) : '0;
      chroma_addr  <= s2_block ? s2_caddr : '0;
      frame_end    <= s2_fend;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s1_valid     <= pop;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
    end
  end

endmodule

`default_nettype wire

[src/bgra_to_nv12_converter_core.sv]
`default_nettype none

// BGRA to NV12 converter. Pixels come in raster order, one 32-bit BGRA word
// per beat, and the core takes one pixel every clock cycle for as long as
// the result side keeps up; the single line store port and the three-stage
// back pipeline are what set that figure. Every pixel inside the kept area
// (source size cropped to even, limited to MAX_WIDTH x MAX_HEIGHT) gives one
// result beat with its luma and Y-plane offset; the bottom-right pixel of
// each 2x2 block also carries U, V and the UV-plane offset. Dropped pixels
// give no beat. A four-beat queue parts the pixel counters from the
// arithmetic, so a stalled result side stops input only once that queue
// fills. The line store needs no clearing after reset. The user must write
// sizes over the register port only while idle; the core does not check.

module bgra_to_nv12_converter_core #(
  parameter int MAX_WIDTH  = b2nv12_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = b2nv12_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // register port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [b2nv12_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [b2nv12_pkg::CFG_W-1:0]     pwdata,
  output logic [b2nv12_pkg::CFG_W-1:0]          prdata,
  output logic                                  pready,
  // pixel channel
  input  wire logic                             pixel_valid,
  output logic                                  pixel_stall,
  input  wire logic [b2nv12_pkg::PIXEL_W-1:0]   pixel,
  // result channel
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic [b2nv12_pkg::CHAN_W-1:0]         luma,
  output logic [b2nv12_pkg::LADDR_W-1:0]        luma_addr,
  output logic                                  chroma_valid,
  output logic [b2nv12_pkg::CHAN_W-1:0]         chroma_u,
  output logic [b2nv12_pkg::CHAN_W-1:0]         chroma_v,
  output logic [b2nv12_pkg::CADDR_W-1:0]        chroma_addr,
  output logic                                  frame_end
);
  import b2nv12_pkg::*;

  logic [CNT_W-1:0] source_width;
  logic [CNT_W-1:0] source_height;
  logic             cfg_write;

  logic  push, pop, queue_full, queue_not_empty;
  beat_t push_beat, pop_beat;

  // size registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= WIDTH_RESET;
      source_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_WIDTH:  source_width  <= pwdata[CNT_W-1:0];
        REG_HEIGHT: source_height <= pwdata[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // read back; byte lanes within a word are not decoded
  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = {(CFG_W - CNT_W)'(0), source_width};
      REG_HEIGHT: prdata = {(CFG_W - CNT_W)'(0), source_height};
      default:    prdata = '0;
    endcase
  end

  b2nv12_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .source_width  (source_width),
    .source_height (source_height),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .pixel         (pixel),
    .queue_full    (queue_full),
    .push          (push),
    .push_beat     (push_beat)
  );

  b2nv12_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_beat (push_beat),
    .full      (queue_full),
    .pop       (pop),
    .pop_beat  (pop_beat),
    .not_empty (queue_not_empty)
  );

  b2nv12_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .not_empty    (queue_not_empty),
    .pop_beat     (pop_beat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .luma         (luma),
    .luma_addr    (luma_addr),
    .chroma_valid (chroma_valid),
    .chroma_u     (chroma_u),
    .chroma_v     (chroma_v),
    .chroma_addr  (chroma_addr),
    .frame_end    (frame_end)
  );

endmodule

`default_nettype wire

[src/b2nv12_checker.sv]
`default_nettype none

module b2nv12_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [7:0]  luma,
  input wire logic [23:0] luma_addr,
  input wire logic        chroma_valid,
  input wire logic [7:0]  chroma_u,
  input wire logic [7:0]  chroma_v,
  input wire logic [22:0] chroma_addr,
  input wire logic        frame_end
);

  // nothing comes out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat right after reset");

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(luma)
      && $stable(luma_addr) && $stable(chroma_valid) && $stable(chroma_u)
      && $stable(chroma_v) && $stable(chroma_addr) && $stable(frame_end))
    else $error("stalled result beat changed");

  // beats without a block carry zero chroma
  a_no_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !chroma_valid |-> chroma_u == 8'd0 && chroma_v == 8'd0
      && chroma_addr == 23'd0)
    else $error("chroma fields set without a block");

  // UV pairs sit at even offsets
  a_chroma_even: assert property (@(posedge clk) disable iff (rst)
    result_valid && chroma_valid |-> !chroma_addr[0])
    else $error("odd UV offset");

  // last kept pixel always closes a 2x2 block
  a_end_block: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_end |-> chroma_valid)
    else $error("frame end without a block");

endmodule

bind bgra_to_nv12_converter_core b2nv12_checker u_checker (.*);

`default_nettype wire

[sim/tb_bgra_to_nv12_converter_core.sv]
module tb_bgra_to_nv12_converter_core;
  import b2nv12_pkg::*;

  localparam int FRAME_MAX_W    = MAX_WIDTH_DEF;
  localparam int FRAME_MAX_H    = MAX_HEIGHT_DEF;
  localparam int DRAIN_CYCLES   = 16;    // pipeline plus skid queue, with margin
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MODE_ITEMS     = 370;

  // one result beat as the core presents it
  typedef struct packed {
    logic [CHAN_W-1:0]  luma;
    logic [LADDR_W-1:0] luma_addr;
    logic               chroma_valid;
    logic [CHAN_W-1:0]  chroma_u;
    logic [CHAN_W-1:0]  chroma_v;
    logic [CADDR_W-1:0] chroma_addr;
    logic               frame_end;
  } nv12_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [CFG_W-1:0]    pwdata  = '0;
  logic [CFG_W-1:0]    prdata;
  logic                pready;

  logic                pixel_valid = 1'b0;
  logic                pixel_stall;
  logic [PIXEL_W-1:0]  pixel = '0;

  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [CHAN_W-1:0]   luma;
  logic [LADDR_W-1:0]  luma_addr;
  logic                chroma_valid;
  logic [CHAN_W-1:0]   chroma_u;
  logic [CHAN_W-1:0]   chroma_v;
  logic [CADDR_W-1:0]  chroma_addr;
  logic                frame_end;

  bgra_to_nv12_converter_core dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .luma         (luma),
    .luma_addr    (luma_addr),
    .chroma_valid (chroma_valid),
    .chroma_u     (chroma_u),
    .chroma_v     (chroma_v),
    .chroma_addr  (chroma_addr),
    .frame_end    (frame_end)
  );

  always #10 clk = ~clk;

  // stimulus and expected beats
  logic [PIXEL_W-1:0] pending_pixels[$];
  nv12_beat_t         expected_beats[$];

  int send_idle_pct = 37;
  int recv_idle_pct = 84;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_left = 0;

  int pixels_sent = 0;
  int pixels_taken = 0;
  int beats_seen = 0;
  int chroma_seen = 0;
  int frames_seen = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  // shadow of the size registers and of the conversion state
  logic [CNT_W-1:0]   cfg_width  = WIDTH_RESET;
  logic [CNT_W-1:0]   cfg_height = HEIGHT_RESET;
  logic [23:0]        held_left = '0;
  int                 pair_b [FRAME_MAX_W/2];
  int                 pair_g [FRAME_MAX_W/2];
  int                 pair_r [FRAME_MAX_W/2];
  int                 col_cnt = 0;
  int                 row_cnt = 0;
  logic [LADDR_W-1:0] luma_off = '0;
  logic [CADDR_W-1:0] chroma_off = '0;

  wire pix_take = pixel_valid && !pixel_stall;
  wire res_take = result_valid && !result_stall;

  // floor shift by 256, recenter, saturate to a byte
  function automatic logic [CHAN_W-1:0] chroma_sat(input int x);
    int q;
    q = (x >>> 8) + 128;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[CHAN_W-1:0];
  endfunction

  // advance the converter state by one pixel, queue its beat if it is kept
  function automatic void predict_nv12(input logic [PIXEL_W-1:0] px);
    nv12_beat_t beat;
    int kw, kh, col, row, idx, bs, gs, rs, ab, ag, ar;
    logic [7:0] b, g, r;
    b = px[7:0];
    g = px[15:8];
    r = px[23:16];
    kw = cfg_width;
    if (kw > FRAME_MAX_W) kw = FRAME_MAX_W;
    kw = kw & ~1;
    kh = cfg_height;
    if (kh > FRAME_MAX_H) kh = FRAME_MAX_H;
    kh = kh & ~1;
    col = col_cnt;
    row = row_cnt;

    if (col < kw && row < kh) begin
      beat = '0;
      beat.luma = 8'((77 * r + 150 * g + 29 * b) >> 8);
      beat.luma_addr = luma_off;
      if (col % 2 == 0) begin
        held_left = px[23:0];
      end else begin
        idx = col / 2;
        bs = held_left[7:0] + b;
        gs = held_left[15:8] + g;
        rs = held_left[23:16] + r;
        if (row % 2 == 0) begin
          pair_b[idx] = bs;
          pair_g[idx] = gs;
          pair_r[idx] = rs;
        end else begin
          ab = (pair_b[idx] + bs) >> 2;
          ag = (pair_g[idx] + gs) >> 2;
          ar = (pair_r[idx] + rs) >> 2;
          beat.chroma_valid = 1'b1;
          beat.chroma_u = chroma_sat(-43 * ar - 85 * ag + 128 * ab);
          beat.chroma_v = chroma_sat(128 * ar - 107 * ag - 21 * ab);
          beat.chroma_addr = chroma_off;
          chroma_off = chroma_off + 2;
        end
      end
      beat.frame_end = (row + 1 == kh) && (col + 1 == kw);
      luma_off = luma_off + 1;
      expected_beats.insert(expected_beats.size(), beat);
    end

    // raster counters; offsets restart only when the frame wraps
    if (col + 1 >= cfg_width) begin
      col_cnt = 0;
      if (row + 1 >= cfg_height) begin
        row_cnt = 0;
        luma_off = '0;
        chroma_off = '0;
      end else begin
        row_cnt = row + 1;
      end
    end else begin
      col_cnt = col + 1;
    end
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pix_take) begin
        predict_nv12(pixel);
        pixels_taken <= pixels_taken + 1;
      end
      if (!pixel_valid || !pixel_stall) begin
        if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          pixel_valid <= 1'b1;
          pixel <= pending_pixels.pop_front();
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    nv12_beat_t got, want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (res_take) begin
        got.luma = luma;
        got.luma_addr = luma_addr;
        got.chroma_valid = chroma_valid;
        got.chroma_u = chroma_u;
        got.chroma_v = chroma_v;
        got.chroma_addr = chroma_addr;
        got.frame_end = frame_end;
        beats_seen <= beats_seen + 1;
        if (chroma_valid) chroma_seen <= chroma_seen + 1;
        if (frame_end) frames_seen <= frames_seen + 1;
        if (expected_beats.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("Unexpected beat %0d: luma=%0h addr=%0h", beats_seen, luma, luma_addr);
        end else begin
          want = expected_beats.pop_front();
          if (got.luma !== want.luma || got.luma_addr !== want.luma_addr ||
              got.chroma_valid !== want.chroma_valid || got.chroma_u !== want.chroma_u ||
              got.chroma_v !== want.chroma_v || got.chroma_addr !== want.chroma_addr ||
              got.frame_end !== want.frame_end) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10) begin
              $display("Mismatch at beat %0d", beats_seen);
              $display("  expected luma=%02h addr=%06h cv=%0b u=%02h v=%02h caddr=%06h fe=%0b",
                       want.luma, want.luma_addr, want.chroma_valid, want.chroma_u,
                       want.chroma_v, want.chroma_addr, want.frame_end);
              $display("  actual   luma=%02h addr=%06h cv=%0b u=%02h v=%02h caddr=%06h fe=%0b",
                       got.luma, got.luma_addr, got.chroma_valid, got.chroma_u,
                       got.chroma_v, got.chroma_addr, got.frame_end);
            end
          end
        end
      end

      // long back-pressure stretch once, otherwise random stalls
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        result_stall <= 1'b1;
      end else if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // watchdog on beats on either channel
  always @(posedge clk) begin
    if (rst || pix_take || res_take) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_beats.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic offer_pixel(input logic [PIXEL_W-1:0] px);
    pending_pixels.insert(pending_pixels.size(), px);
    pixels_sent++;
  endtask

  // random word, sometimes with every channel saturated to 0 or 255
  function automatic logic [PIXEL_W-1:0] random_pixel();
    logic [PIXEL_W-1:0] px;
    px = $urandom;
    if ($urandom_range(0, 5) == 0) begin
      px[7:0]   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      px[15:8]  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      px[23:16] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return px;
  endfunction

  // queue one whole frame so the counters end at the origin
  task automatic queue_frame(input int w, input int h);
    int n;
    n = (w < 1 ? 1 : w) * (h < 1 ? 1 : h);
    repeat (n) offer_pixel(random_pixel());
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pixels_taken != pixels_sent || expected_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write: setup then access, upper data bits are don't-care
  task automatic reg_write(input logic which, input int value);
    logic [CFG_W-1:0] data;
    data = $urandom;
    data[CNT_W-1:0] = value[CNT_W-1:0];
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (which == REG_WIDTH) cfg_width = data[CNT_W-1:0];
    else cfg_height = data[CNT_W-1:0];
  endtask

  task automatic set_frame_size(input int w, input int h);
    wait_idle();
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    int mode_items, w, h;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // 4x4 frame: saturated blocks drive U and V to both clamps
    set_frame_size(4, 4);
    offer_pixel(32'h00FF0000); offer_pixel(32'hFFFF0000);
    offer_pixel(32'h000000FF); offer_pixel(32'h800000FF);
    offer_pixel(32'hA5FF0000); offer_pixel(32'h5AFF0000);
    offer_pixel(32'h7F0000FF); offer_pixel(32'hFF0000FF);
    offer_pixel(32'h00FFFF00); offer_pixel(32'hFFFFFF00);
    offer_pixel(32'h0000FFFF); offer_pixel(32'h1200FFFF);
    offer_pixel(32'h33FFFF00); offer_pixel(32'hCCFFFF00);
    offer_pixel(32'hEE00FFFF); offer_pixel(32'h0100FFFF);

    // tiny frames keep nothing but still step the counters
    set_frame_size(1, 2);
    offer_pixel(32'hFFFFFFFF);
    offer_pixel(32'h00000000);
    set_frame_size(0, 0);
    offer_pixel(32'hFFFFFFFF);

    // height shrinks at a row-pair boundary mid-frame
    set_frame_size(2, 8);
    offer_pixel(32'hFFFFFFFF); offer_pixel(32'hFFFFFFFF);
    offer_pixel(32'h00000000); offer_pixel(32'h00000000);
    wait_idle();
    reg_write(REG_HEIGHT, 6);
    repeat (8) offer_pixel(random_pixel());

    // random frames under three idling patterns
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: set_idling(37, 84);
        1: set_idling(84, 37);
        default: set_idling(0, 0);
      endcase
      mode_items = 0;
      while (mode_items < MODE_ITEMS) begin
        case ($urandom_range(0, 9))
          0: begin
            w = $urandom_range(0, 5);
            h = $urandom_range(0, 5);
          end
          1: begin
            w = $urandom_range(16, 40);
            h = $urandom_range(16, 20);
          end
          default: begin
            w = $urandom_range(16, 33);
            h = $urandom_range(2, 9);
          end
        endcase
        set_frame_size(w, h);
        queue_frame(w, h);
        mode_items += (w < 1 ? 1 : w) * (h < 1 ? 1 : h);
        if (mode == 2 && w >= 16) long_hold_req = 1'b1;
      end
    end

    wait_idle();
    fail_count += expected_beats.size();
    $display("Converted %0d pixels into %0d result beats (%0d with chroma, %0d frame ends)",
             pixels_taken, beats_seen, chroma_seen, frames_seen);
    $display("Sizes from 0x0 to 40x20, clamped chroma, mid-frame height change, long stall");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
